FILE: rtl/core/hepd_pkg.sv
// Shared types, constants and helper functions for the entity / percent decoder.
// No dependencies; every other file in rtl/core but hepd_checker imports this package.
package hepd_pkg;

    localparam int ENT_NUM   = 4;
    localparam int ENT_DEPTH = 5;   // pending entity prefix bytes
    localparam int FEED_MAX  = 6;   // bytes one item can hand to the percent unit

    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    // Entity lengths and replacement characters, entity 0 in the lowest slot:
    // amp, quot, #39, #34
    localparam logic [ENT_NUM-1:0][2:0] ENT_LEN  = {3'd5, 3'd5, 3'd6, 3'd5};
    localparam logic [ENT_NUM-1:0][7:0] ENT_CHAR = {8'h22, 8'h27, 8'h22, 8'h26};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_FLUSH
    } hepd_state_t;

    // Bytes handed from the entity stage to the percent unit for one item
    typedef struct packed {
        logic [FEED_MAX-1:0][7:0] bytes;
        logic [2:0]               len;
    } ent_load_t;

    typedef struct packed {
        logic feed;
        logic flush;
        logic advance;
    } pct_req_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] emit_byte;
        logic       consume;
        logic       empty_next;
    } pct_rsp_t;

    // Character p of entity k; zero past its end
    function automatic logic [7:0] ent_text(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        if (p == 3'd0) begin
            c = CH_AMP;
        end else begin
            case (k)
                2'd0: begin
                    case (p)
                        3'd1:    c = 8'h61;  // a
                        3'd2:    c = 8'h6d;  // m
                        3'd3:    c = 8'h70;  // p
                        3'd4:    c = 8'h3b;  // ;
                        default: c = 8'h00;
                    endcase
                end
                2'd1: begin
                    case (p)
                        3'd1:    c = 8'h71;  // q
                        3'd2:    c = 8'h75;  // u
                        3'd3:    c = 8'h6f;  // o
                        3'd4:    c = 8'h74;  // t
                        3'd5:    c = 8'h3b;  // ;
                        default: c = 8'h00;
                    endcase
                end
                2'd2: begin
                    case (p)
                        3'd1:    c = 8'h23;  // #
                        3'd2:    c = 8'h33;  // 3
                        3'd3:    c = 8'h39;  // 9
                        3'd4:    c = 8'h3b;  // ;
                        default: c = 8'h00;
                    endcase
                end
                default: begin
                    case (p)
                        3'd1:    c = 8'h23;  // #
                        3'd2:    c = 8'h33;  // 3
                        3'd3:    c = 8'h34;  // 4
                        3'd4:    c = 8'h3b;  // ;
                        default: c = 8'h00;
                    endcase
                end
            endcase
        end
        return c;
    endfunction

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 its value
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, b[3:0]};
        end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/html_entity_percent_decoder_unit.sv
// Byte-stream decoder: HTML entities (&amp; &quot; &#39; &#34;) then %XX escapes.
// An item is accepted while idle; the entity stage then hands 0 to 6 bytes to a
// single percent unit that examines or flushes one byte per cycle and emits at
// most one byte per cycle, unless the output register holds it back. Each byte
// handed on from a broken entity is examined in turn, a failed escape passes the
// held bytes on before the failing byte is examined again, and after an item
// marked last the pending percent bytes are flushed one at a time. s_tready is
// high only between items. Emitted bytes are held in an output register that
// stalls the percent unit when it has a byte to emit while the register is full
// and m_tready is low. Depends on hepd_pkg, hepd_ent, hepd_pct.
module html_entity_percent_decoder_unit
    import hepd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    hepd_state_t state_reg, state_next;

    logic                     accept;
    ent_load_t                load;
    pct_req_t                 req;
    pct_rsp_t                 rsp;
    logic [FEED_MAX-1:0][7:0] feed_reg;
    logic [2:0]               feed_len_reg;
    logic [2:0]               feed_idx_reg, feed_idx_next;
    logic                     last_reg;
    logic                     feed_end;
    logic                     out_free;
    logic                     is_final;
    logic                     m_tvalid_reg;
    logic [7:0]               m_tdata_reg;
    logic                     m_tlast_reg;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign feed_end = rsp.consume && ((feed_idx_reg + 3'd1) == feed_len_reg);

    hepd_ent u_ent (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .load    (load)
    );

    hepd_pct u_pct (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .in_byte (feed_reg[feed_idx_reg]),
        .rsp     (rsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (load.len != 3'd0) begin
                        state_next = ST_FEED;
                    end else if (s_tlast) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FEED: begin
                if (req.advance && feed_end) begin
                    state_next = last_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (req.advance && rsp.empty_next) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready    = 1'b0;
        req.feed    = 1'b0;
        req.flush   = 1'b0;
        is_final    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_FEED: begin
                req.feed = 1'b1;
                is_final = last_reg && feed_end && rsp.empty_next;
            end
            ST_FLUSH: begin
                req.flush = 1'b1;
                is_final  = last_reg && rsp.empty_next;
            end
            default: s_tready = 1'b0;
        endcase
        req.advance   = (req.feed || req.flush) && (!rsp.emit || out_free);
        feed_idx_next = feed_idx_reg;
        if (accept) begin
            feed_idx_next = 3'd0;
        end else if (req.feed && req.advance && rsp.consume) begin
            feed_idx_next = feed_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            feed_idx_reg <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            feed_idx_reg <= feed_idx_next;
            if (rsp.emit && req.advance) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            feed_reg     <= load.bytes;
            feed_len_reg <= load.len;
            last_reg     <= s_tlast;
        end
        if (rsp.emit && req.advance) begin
            m_tdata_reg <= rsp.emit_byte;
            m_tlast_reg <= is_final;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: rtl/core/hepd_ent.sv
// Entity matching stage: holds the pending entity prefix and decides, per item,
// which bytes go on to the percent unit. Depends on hepd_pkg.
module hepd_ent
    import hepd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output ent_load_t  load
);

    logic [ENT_DEPTH-1:0][7:0] ebuf_reg;
    logic [2:0]                ecnt_reg, ecnt_next;
    logic [ENT_NUM-1:0]        alive_reg, alive_next;

    logic [ENT_NUM-1:0] hit;
    logic [ENT_NUM-1:0] full;
    logic               any_full;
    logic               prefix;
    logic [7:0]         match_char;
    logic               restart;
    logic               store;

    always_comb begin
        match_char = ENT_CHAR[0];
        for (int k = 0; k < ENT_NUM; k++) begin
            hit[k]  = alive_reg[k] && (ecnt_reg < ENT_LEN[k])
                      && (in_byte == ent_text(2'(k), ecnt_reg));
            full[k] = hit[k] && ((ecnt_reg + 3'd1) == ENT_LEN[k]);
        end
        for (int k = ENT_NUM - 1; k >= 0; k--) begin
            if (full[k]) begin
                match_char = ENT_CHAR[k];
            end
        end
        any_full = |full;
        prefix   = (|hit) && !any_full;
        // a fresh '&' after a mismatch opens a new entity unless the string ends
        restart  = !any_full && !prefix && (in_byte == CH_AMP) && !in_last;
        store    = prefix && !in_last;

        // pending bytes first, then the new byte
        for (int i = 0; i < FEED_MAX; i++) begin
            load.bytes[i] = in_byte;
        end
        if (any_full) begin
            load.bytes[0] = match_char;
        end else begin
            for (int i = 0; i < ENT_DEPTH; i++) begin
                if (3'(i) < ecnt_reg) begin
                    load.bytes[i] = ebuf_reg[i];
                end
            end
        end

        if (any_full) begin
            load.len = 3'd1;
        end else if (store || restart) begin
            load.len = restart ? ecnt_reg : 3'd0;
        end else begin
            load.len = ecnt_reg + 3'd1;
        end

        ecnt_next  = ecnt_reg;
        alive_next = alive_reg;
        if (accept) begin
            if (store) begin
                ecnt_next  = ecnt_reg + 3'd1;
                alive_next = hit;
            end else begin
                ecnt_next  = restart ? 3'd1 : 3'd0;
                alive_next = '1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ecnt_reg  <= 3'd0;
            alive_reg <= '1;
        end else begin
            ecnt_reg  <= ecnt_next;
            alive_reg <= alive_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (restart) begin
                ebuf_reg[0] <= CH_AMP;
            end else if (store) begin
                for (int i = 0; i < ENT_DEPTH; i++) begin
                    if (ecnt_reg == 3'(i)) begin
                        ebuf_reg[i] <= in_byte;
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/core/hepd_pct.sv
// Percent-escape unit: examines one byte or flushes one pending byte per step,
// giving at most one decoded byte per step. Depends on hepd_pkg.
module hepd_pct
    import hepd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pct_req_t   req,
    input  logic [7:0] in_byte,
    output pct_rsp_t   rsp
);

    logic [1:0] pcnt_reg, pcnt_next;
    logic [7:0] pbuf0_reg, pbuf0_next;
    logic [7:0] pbuf1_reg, pbuf1_next;
    logic [4:0] hb;
    logic [4:0] hp;

    always_comb begin
        hb          = hex_val(in_byte);
        hp          = hex_val(pbuf1_reg);
        rsp.emit      = 1'b0;
        rsp.emit_byte = in_byte;
        rsp.consume   = 1'b0;
        pcnt_next   = pcnt_reg;
        pbuf0_next  = pbuf0_reg;
        pbuf1_next  = pbuf1_reg;

        if (req.flush) begin
            if (pcnt_reg != 2'd0) begin
                rsp.emit      = 1'b1;
                rsp.emit_byte = pbuf0_reg;
                pbuf0_next  = pbuf1_reg;
                pcnt_next   = pcnt_reg - 2'd1;
            end
        end else if (req.feed) begin
            case (pcnt_reg)
                2'd0: begin
                    rsp.consume = 1'b1;
                    if (in_byte == CH_PERCENT) begin
                        pbuf0_next = in_byte;
                        pcnt_next  = 2'd1;
                    end else begin
                        rsp.emit = 1'b1;
                    end
                end
                2'd1: begin
                    if (hb[4]) begin
                        rsp.consume = 1'b1;
                        pbuf1_next  = in_byte;
                        pcnt_next   = 2'd2;
                    end else begin
                        // pass the '%' on, re-examine the byte next step
                        rsp.emit      = 1'b1;
                        rsp.emit_byte = pbuf0_reg;
                        pcnt_next     = 2'd0;
                    end
                end
                default: begin
                    rsp.emit = 1'b1;
                    if (hb[4]) begin
                        rsp.consume   = 1'b1;
                        rsp.emit_byte = {hp[3:0], hb[3:0]};
                        pcnt_next     = 2'd0;
                    end else begin
                        // shift the first digit down; the next step passes it on
                        rsp.emit_byte = pbuf0_reg;
                        pbuf0_next    = pbuf1_reg;
                        pcnt_next     = 2'd1;
                    end
                end
            endcase
        end
        rsp.empty_next = (pcnt_next == 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcnt_reg <= 2'd0;
        end else if (req.advance) begin
            pcnt_reg <= pcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.advance) begin
            pbuf0_reg <= pbuf0_next;
            pbuf1_reg <= pbuf1_next;
        end
    end

endmodule

FILE: rtl/core/hepd_checker.sv
// Port-level checks for the decoder top level, bound in below.
// Depends only on the ports of html_entity_percent_decoder_unit.
module hepd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic       last_in;
    logic       last_out;
    logic [1:0] owed_reg, owed_next;

    assign last_in  = s_tvalid && s_tready && s_tlast;
    assign last_out = m_tvalid && m_tready && m_tlast;

    // count last input items whose final byte has not yet left
    always_comb begin
        owed_next = owed_reg;
        if (last_in && !last_out) begin
            owed_next = owed_reg + 2'd1;
        end else if (!last_in && last_out) begin
            owed_next = owed_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owed_reg <= 2'd0;
        end else begin
            owed_reg <= owed_next;
        end
    end

    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    a_last_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> owed_reg != 2'd0)
        else $error("tlast on a result with no last input item outstanding");

    a_busy_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result item produced while the block was idle");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind html_entity_percent_decoder_unit hepd_checker u_hepd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
